/* src/asid_pkg.sv */
// ----------------------------------------------------------------------------
// Search table package
// Shared types, sizes and codes for the linear-search table with append,
// search, delete, insert, read and clear operations.
// ----------------------------------------------------------------------------
package asid_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 128;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Fixed field widths of the channels.
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // Request beat.
   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic                      found;
      logic [INDEX_W-1:0]        found_index;
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

endpackage

/* src/array_search_insert_delete.sv */
// ----------------------------------------------------------------------------
// Search table top level
// Ordered table of signed 32-bit entries kept in one synchronous memory,
// with linear search, delete with gap closing and insert with shifting.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/ready), one beat per
//   operation, and each produces exactly one response beat on rsp_.
//   The block works on one operation at a time. req_ready is high while
//   it is idle, even when an earlier response still sits in the output
//   register waiting for rsp_ready.
//   Append, clear, unused codes and a rejected read need no memory read; a
//   read waits for the memory data. Search, delete and insert scan the
//   table from entry 0 and stop after the first match; delete then moves
//   the entries above a match down, and insert moves the entries from
//   the position up and writes the key, or writes it alone at the tail.
//   The single memory read port is registered: the scan and the shifts
//   visit one entry per cycle. Reset empties the table (count to zero);
//   the memory needs no clearing pass, since only entries below the count
//   are ever read.
//   When rsp_ready is low the finished response is held unchanged in the
//   output register and the next operation waits before it completes.
// ----------------------------------------------------------------------------
module array_search_insert_delete (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  asid_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asid_pkg::rsp_type rsp_data
);
   import asid_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN     = 7'b0000010,
      S_DECIDE   = 7'b0000100,
      S_SHIFT_DN = 7'b0001000,
      S_SHIFT_UP = 7'b0010000,
      S_READ     = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   // Table memory with a registered read port.
   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // Control state.
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Operation and working registers.
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                hit_ff, hit_in;
   logic [ADDR_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [VALUE_W-1:0]  rdval_ff, rdval_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] idx_dec;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] pos_ext;
   logic             cnt_full;
   logic             out_free;

   assign idx_inc  = idx_ff + CNT_W'(1);
   assign idx_dec  = idx_ff - CNT_W'(1);
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign cnt_full = (cnt_ff >= CNT_W'(TABLE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Position compared at count width; positions past the counter range
   // are always out of range.
   always_comb begin
      if (POS_W > CNT_W) begin
         pos_ext = (pos_ff > POS_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH + 1)
                                                  : CNT_W'(pos_ff);
      end else begin
         pos_ext = CNT_W'(pos_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Memory port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer: decodes a request, scans, shifts and forms the response.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      rdval_in     = rdval_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[ADDR_W-1:0];
      wr_data      = key_ff;

      // The response register empties when the receiver takes the beat.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.opcode;
               key_in     = req_data.value;
               pos_in     = req_data.position;
               idx_in     = '0;
               hit_in     = 1'b0;
               hit_idx_in = '0;
               rdval_in   = '0;
               status_in  = ST_OK;
               state_in   = S_DONE;
               unique case (req_data.opcode)
                  OP_APPEND: begin
                     if (cnt_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[ADDR_W-1:0];
                        wr_data = req_data.value;
                        cnt_in  = cnt_inc;
                     end
                  end
                  OP_SEARCH, OP_DELETE, OP_INSERT: begin
                     state_in = S_SCAN;
                  end
                  OP_READ: begin
                     if (CNT_W'(req_data.position) < cnt_ff &&
                         req_data.position < POS_W'(TABLE_DEPTH)) begin
                        rd_addr  = req_data.position[ADDR_W-1:0];
                        state_in = S_READ;
                     end else begin
                        status_in = ST_BAD_POS;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Linear scan: one read issued per cycle, compared when the registered data returns.
         S_SCAN: begin
            if (pend_ff && rd_data_ff == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_addr_ff;
               state_in   = S_DECIDE;
            end else if (idx_ff < cnt_ff) begin
               rd_addr      = idx_ff[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[ADDR_W-1:0];
               idx_in       = idx_inc;
            end else begin
               state_in = S_DECIDE;
            end
         end

         // Outcome of the search for each searching operation.
         S_DECIDE: begin
            state_in = S_DONE;
            priority case (op_ff)
               OP_DELETE: begin
                  if (!hit_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     idx_in   = CNT_W'(hit_idx_ff) + CNT_W'(1);
                     state_in = S_SHIFT_DN;
                  end
               end
               OP_INSERT: begin
                  if (hit_ff) begin
                     status_in = ST_PRESENT;
                  end else if (pos_ext > cnt_ff) begin
                     status_in = ST_BAD_POS;
                  end else if (cnt_full) begin
                     status_in = ST_FULL;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
               default: begin
                  status_in = hit_ff ? ST_OK : ST_NOT_FOUND;
               end
            endcase
         end

         // Delete: entry i+1 moves to i; each entry is read, then written from the registered data.
         S_SHIFT_DN: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data_ff;
            end
            if (idx_ff < cnt_ff) begin
               rd_addr      = idx_ff[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_dec[ADDR_W-1:0];
               idx_in       = idx_inc;
            end else begin
               cnt_in   = cnt_dec;
               state_in = S_DONE;
            end
         end

         // Insert: entry i-1 moves to i from the top down, then the key.
         S_SHIFT_UP: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data_ff;
            end
            if (idx_ff > pos_ext) begin
               rd_addr      = idx_dec[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[ADDR_W-1:0];
               idx_in       = idx_dec;
            end else if (!pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[ADDR_W-1:0];
               wr_data  = key_ff;
               cnt_in   = cnt_inc;
               state_in = S_DONE;
            end
         end

         // Read data comes from the registered memory read port.
         S_READ: begin
            rdval_in = rd_data_ff;
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (out_free) begin
               rsp_in.found       = hit_ff;
               rsp_in.found_index = INDEX_W'(hit_idx_ff);
               rsp_in.read_value  = rdval_ff;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = COUNT_W'(cnt_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      rdval_ff     <= rdval_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

endmodule

/* src/asid_check.sv */
// ----------------------------------------------------------------------------
// Search table port checker
// Watches the top level's ports and checks response consistency over time.
// ----------------------------------------------------------------------------
module asid_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input asid_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input asid_pkg::rsp_type rsp_data
);
   import asid_pkg::*;

   // A stalled response beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // The entry count never exceeds the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= COUNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A miss reports no match and a zero index.
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.found_index == '0)
      else $error("index reported without a match");

   // Not found and a match never come together.
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NOT_FOUND |-> !rsp_data.found)
      else $error("not-found status with a match");

   // A full table rejection only happens with the table at capacity.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL
         |-> rsp_data.entry_count == COUNT_W'(TABLE_DEPTH))
      else $error("full status with room left");

endmodule

bind array_search_insert_delete asid_check u_asid_check (.*);
